>>> rtl/gtpdc_pkg.sv
package gtpdc_pkg;

  localparam int unsigned POSITION_BITS    = 16;
  localparam int unsigned GAIN_TABLE_DEPTH = 1024;
  localparam int unsigned GAIN_IDX_BITS    = $clog2(GAIN_TABLE_DEPTH);

  localparam int unsigned ANGLE_BITS  = 16;
  localparam int unsigned SPEED_BITS  = 12;
  localparam int unsigned RADIUS_BITS = 12;
  localparam int unsigned SLOW_BITS   = 15;
  localparam int unsigned GAIN_BITS   = 16;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 15;

  // CORDIC datapath: difference (P+1), scale by 2^8, growth under 4, one guard bit.
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned STEP_BITS    = $clog2(CORDIC_STEPS);
  localparam int unsigned CORDIC_BITS  = POSITION_BITS + 1 + 8 + 3;
  localparam int unsigned ZACC_BITS    = ANGLE_BITS + 2;

  localparam int unsigned MUL_A_BITS = (CORDIC_BITS > 28) ? CORDIC_BITS : 28;
  localparam int unsigned MUL_B_BITS = 16;
  localparam int unsigned PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
  localparam int unsigned DIST_BITS  = PROD_BITS - 24;
  localparam int unsigned QUOT_BITS  = SPEED_BITS + 1;
  localparam int unsigned REM_BITS   = PROD_BITS + 1;

  localparam logic [15:0] INV_CORDIC_GAIN = 16'd39797;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MAX_SPEED      = 2'd0,
    CFG_ARRIVAL_RADIUS = 2'd1,
    CFG_SLOW_DISTANCE  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_POSE_TICK  = 1'b0,
    CMD_SET_TARGET = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                             command;
    logic signed [POSITION_BITS-1:0]  robot_x;
    logic signed [POSITION_BITS-1:0]  robot_z;
    logic signed [ANGLE_BITS-1:0]     robot_heading;
    logic signed [POSITION_BITS-1:0]  new_target_x;
    logic signed [POSITION_BITS-1:0]  new_target_y;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_BITS-1:0]        advance_speed;
    logic signed [ANGLE_BITS-1:0] rotation;
    logic                         arrived;
  } out_item_t;

  typedef logic [ZACC_BITS-1:0] atan_rom_t [CORDIC_STEPS];
  localparam atan_rom_t ATAN_ROM = '{
    18'd8192, 18'd4836, 18'd2555, 18'd1297, 18'd651, 18'd326, 18'd163, 18'd81,
    18'd41, 18'd20, 18'd10, 18'd5, 18'd3, 18'd1, 18'd1, 18'd0
  };

  // Floor quotient of a 64-bit value by a small positive integer, bit by bit.
  function automatic longint unsigned div_small(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned rem;
    longint unsigned quo;
    rem = 64'd0;
    quo = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  // Gain entry i is exp(-(i*pi/DEPTH)^2) in Q0.16, built by a series in Q30.
  function automatic logic [GAIN_BITS-1:0] gain_entry(input longint unsigned i);
    longint unsigned pi_q30;
    longint unsigned one_q30;
    longint unsigned b;
    longint unsigned x;
    longint unsigned t;
    longint unsigned term;
    longint          sum;
    longint unsigned s;
    longint unsigned r;
    pi_q30  = 64'd3373259426;
    one_q30 = 64'd1 << 30;
    b    = (i * pi_q30) >> GAIN_IDX_BITS;
    x    = (b * b) >> 30;
    t    = x >> 4;
    term = one_q30;
    sum  = longint'(one_q30);
    for (int n = 1; n <= 12; n++) begin
      term = div_small((term * t) >> 30, longint'(n));
      if ((n & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    s = (sum < 0) ? 64'd0 : longint'(sum);
    if (s > one_q30) begin
      s = one_q30;
    end
    for (int n = 0; n < 4; n++) begin
      s = (s * s) >> 30;
    end
    r = (s + (64'd1 << 13)) >> 14;
    return (r > 64'd65535) ? 16'hFFFF : r[GAIN_BITS-1:0];
  endfunction

  typedef logic [GAIN_BITS-1:0] gain_rom_t [GAIN_TABLE_DEPTH];

  function automatic gain_rom_t build_gain_rom();
    gain_rom_t rom;
    for (int i = 0; i < GAIN_TABLE_DEPTH; i++) begin
      rom[i] = gain_entry(longint'(i));
    end
    return rom;
  endfunction

  localparam gain_rom_t GAIN_ROM = build_gain_rom();

endpackage

>>> rtl/gtpdc_if.sv
interface gtpdc_in_if import gtpdc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gtpdc_out_if import gtpdc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/go_to_point_drive_controller_unit.sv
// Channel   Direction  Payload
// in_i      sink       command, robot pose, new target
// out_o     source     advance_speed, rotation, arrived
// cfg_*     write      register index and data, no read-back
//
// A set-target transfer or a tick while disarmed leaves the block in ST_IDLE.
// An armed tick holds the block busy; below slow_distance it runs 16 CORDIC steps,
// three multiplier passes, the gain-table read and 13 divider steps; otherwise the divider
// is skipped, and on arrival the gain path too; a goal on the robot skips the CORDIC.
// Reset clears the configuration to its defaults and disarms the controller.
// A result waits in the output register; while it is not taken, the next finished
// result holds in its last step and in_i stays not ready.
module go_to_point_drive_controller_unit import gtpdc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  gtpdc_in_if.sink                 in_i,
  gtpdc_out_if.source              out_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CORDIC, ST_MAG, ST_DIST, ST_ROM, ST_MUL1, ST_MUL2, ST_DIV, ST_OUT
  } state_e;

  state_e state_q;

  logic [SPEED_BITS-1:0]  max_speed_q;
  logic [RADIUS_BITS-1:0] arrival_radius_q;
  logic [SLOW_BITS-1:0]   slow_distance_q;

  logic signed [POSITION_BITS-1:0] goal_x_q, goal_y_q;
  logic                            goal_active_q;

  logic signed [ANGLE_BITS-1:0]  head_q;
  logic signed [CORDIC_BITS-1:0] x_q, y_q;
  logic signed [ZACC_BITS-1:0]   z_q;
  logic [STEP_BITS-1:0]          k_q;
  logic [PROD_BITS-1:0]          prod_q;
  logic [DIST_BITS-1:0]          dist_q;
  logic [GAIN_IDX_BITS-1:0]      idx_q;
  logic [GAIN_BITS-1:0]          gain_q;
  logic [REM_BITS-1:0]           rem_q;
  logic [REM_BITS-1:0]           dvs_q;
  logic [QUOT_BITS-1:0]          quot_q;
  logic [$clog2(QUOT_BITS)-1:0]  dcnt_q;
  out_item_t                     res_q;
  logic                          out_valid_q;
  out_item_t                     out_data_q;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  logic in_fire;
  assign in_fire = in_i.valid && in_i.ready;

  // The output register takes a finished result when it is empty or being emptied.
  logic out_load;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  // Goal offset from the robot, with the half-plane fold of the CORDIC start.
  logic signed [POSITION_BITS:0]  dx, dz;
  logic signed [CORDIC_BITS-1:0]  x0, y0;
  assign dx = $signed({goal_x_q[POSITION_BITS-1], goal_x_q})
            - $signed({in_i.data.robot_x[POSITION_BITS-1], in_i.data.robot_x});
  assign dz = $signed({goal_y_q[POSITION_BITS-1], goal_y_q})
            - $signed({in_i.data.robot_z[POSITION_BITS-1], in_i.data.robot_z});
  assign x0 = CORDIC_BITS'(dz) <<< 8;
  assign y0 = CORDIC_BITS'(dx) <<< 8;

  // One CORDIC micro-rotation; the shifts floor toward minus infinity.
  logic signed [CORDIC_BITS-1:0] xs, ys;
  assign xs = x_q >>> k_q;
  assign ys = y_q >>> k_q;

  // Shared multiplier.
  logic [MUL_A_BITS-1:0] mul_a;
  logic [MUL_B_BITS-1:0] mul_b;
  logic [PROD_BITS-1:0]  mul_p;
  always_comb begin
    case (state_q)
      ST_MAG: begin
        mul_a = x_q[CORDIC_BITS-1] ? '0 : MUL_A_BITS'(unsigned'(x_q));
        mul_b = INV_CORDIC_GAIN;
      end
      ST_MUL1: begin
        mul_a = MUL_A_BITS'(max_speed_q);
        mul_b = gain_q;
      end
      default: begin
        mul_a = prod_q[MUL_A_BITS-1:0];
        mul_b = MUL_B_BITS'(dist_q);
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Distance in mm and bearing.
  logic [PROD_BITS-1:0]         dist_sum;
  logic [DIST_BITS-1:0]         dist_w;
  logic signed [ANGLE_BITS-1:0] beta;
  logic [ANGLE_BITS:0]          beta_abs;
  logic [ANGLE_BITS+GAIN_IDX_BITS:0] idx_wide;
  assign dist_sum = prod_q + (PROD_BITS'(1) << 23);
  assign dist_w   = dist_sum[PROD_BITS-1:24];
  assign beta     = z_q[ANGLE_BITS-1:0] + head_q;
  assign beta_abs = beta[ANGLE_BITS-1] ? (ANGLE_BITS+1)'(-$signed({beta[ANGLE_BITS-1], beta}))
                                       : (ANGLE_BITS+1)'({1'b0, beta});
  assign idx_wide = (ANGLE_BITS+GAIN_IDX_BITS+1)'(
                      ((ANGLE_BITS+GAIN_IDX_BITS+1)'(beta_abs) * GAIN_TABLE_DEPTH) >> 15);

  logic fast_path;
  assign fast_path = (slow_distance_q == '0) || (dist_q >= DIST_BITS'(slow_distance_q));

  logic [PROD_BITS-1:0] round_fast;
  logic [PROD_BITS-1:0] adv_fast;
  assign round_fast = prod_q + (PROD_BITS'(1) << 15);
  assign adv_fast   = round_fast >> 16;

  logic rem_ge;
  assign rem_ge = (rem_q >= dvs_q);

  // Quotient including the bit decided in the current divider step.
  logic [QUOT_BITS-1:0] quot_next;
  assign quot_next = {quot_q[QUOT_BITS-2:0], rem_ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      max_speed_q      <= SPEED_BITS'(1000);
      arrival_radius_q <= RADIUS_BITS'(100);
      slow_distance_q  <= SLOW_BITS'(1000);
      goal_x_q         <= '0;
      goal_y_q         <= '0;
      goal_active_q    <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_SPEED:      max_speed_q      <= cfg_data_i[SPEED_BITS-1:0];
          CFG_ARRIVAL_RADIUS: arrival_radius_q <= cfg_data_i[RADIUS_BITS-1:0];
          CFG_SLOW_DISTANCE:  slow_distance_q  <= cfg_data_i[SLOW_BITS-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_i.data.command == CMD_SET_TARGET) begin
              goal_x_q      <= in_i.data.new_target_x;
              goal_y_q      <= in_i.data.new_target_y;
              goal_active_q <= 1'b1;
            end else if (goal_active_q) begin
              head_q <= in_i.data.robot_heading;
              k_q    <= '0;
              if (dx == '0 && dz == '0) begin
                x_q     <= '0;
                y_q     <= '0;
                z_q     <= '0;
                state_q <= ST_MAG;
              end else begin
                x_q     <= dz[POSITION_BITS] ? -x0 : x0;
                y_q     <= dz[POSITION_BITS] ? -y0 : y0;
                z_q     <= dz[POSITION_BITS] ? ZACC_BITS'(32768) : '0;
                state_q <= ST_CORDIC;
              end
            end
          end
        end
        ST_CORDIC: begin
          if (y_q > 0) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + $signed(ATAN_ROM[k_q]);
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - $signed(ATAN_ROM[k_q]);
          end
          k_q <= k_q + 1'b1;
          if (k_q == STEP_BITS'(CORDIC_STEPS - 1)) begin
            state_q <= ST_MAG;
          end
        end
        ST_MAG: begin
          prod_q  <= mul_p;
          state_q <= ST_DIST;
        end
        ST_DIST: begin
          dist_q <= dist_w;
          if (dist_w < DIST_BITS'(arrival_radius_q)) begin
            goal_active_q       <= 1'b0;
            res_q.advance_speed <= '0;
            res_q.rotation      <= '0;
            res_q.arrived       <= 1'b1;
            state_q             <= ST_OUT;
          end else begin
            res_q.rotation <= beta;
            res_q.arrived  <= 1'b0;
            idx_q <= (idx_wide > (ANGLE_BITS+GAIN_IDX_BITS+1)'(GAIN_TABLE_DEPTH - 1))
                     ? GAIN_IDX_BITS'(GAIN_TABLE_DEPTH - 1) : idx_wide[GAIN_IDX_BITS-1:0];
            state_q <= ST_ROM;
          end
        end
        ST_ROM: begin
          gain_q  <= GAIN_ROM[idx_q];
          state_q <= ST_MUL1;
        end
        ST_MUL1: begin
          prod_q  <= mul_p;
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          if (fast_path) begin
            res_q.advance_speed <= (adv_fast > PROD_BITS'(max_speed_q)) ? max_speed_q
                                   : adv_fast[SPEED_BITS-1:0];
            state_q <= ST_OUT;
          end else begin
            // Rounded quotient: (P*dist + den/2) / den with den = slow * 2^16.
            rem_q   <= REM_BITS'(mul_p) + (REM_BITS'(slow_distance_q) << 15);
            dvs_q   <= REM_BITS'(slow_distance_q) << (16 + QUOT_BITS - 1);
            quot_q  <= '0;
            dcnt_q  <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_ge) begin
            rem_q <= rem_q - dvs_q;
          end
          quot_q <= quot_next;
          dvs_q  <= dvs_q >> 1;
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == ($clog2(QUOT_BITS))'(QUOT_BITS - 1)) begin
            // The last quotient bit is known now; saturate at the top speed.
            res_q.advance_speed <= (quot_next > QUOT_BITS'(max_speed_q)) ? max_speed_q
                                   : quot_next[SPEED_BITS-1:0];
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_data_q <= res_q;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_arrive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.arrived |-> out_o.data.advance_speed == '0
                                        && out_o.data.rotation == '0)
    else $error("arrival result carries nonzero commands");
  a_set_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.data.command == CMD_SET_TARGET |=> goal_active_q)
    else $error("set target did not arm the controller");
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CORDIC |=> !in_i.ready || $past(k_q) == STEP_BITS'(CORDIC_STEPS - 1))
    else $error("input taken during CORDIC iterations");
`endif

endmodule

>>> bench/testbench.sv
`default_nettype none

module testbench;
  import gtpdc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The write port has room for a fourth index that maps to no register.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_IDX = 2'd3;
  // After the queues empty, DRAIN_CYCLES quiet cycles let the last armed tick drain.
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  gtpdc_in_if  in_ch ();
  gtpdc_out_if out_ch ();

  go_to_point_drive_controller_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state: a private copy of the registers, the goal and the arm flag.
  logic [SPEED_BITS-1:0]  top_speed;
  logic [RADIUS_BITS-1:0] stop_radius;
  logic [SLOW_BITS-1:0]   ramp_distance;
  logic signed [POSITION_BITS-1:0] goal_x;
  logic signed [POSITION_BITS-1:0] goal_y;
  bit armed;

  longint unsigned heading_gain [GAIN_TABLE_DEPTH];
  int cordic_atan [CORDIC_STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                     41, 20, 10, 5, 3, 1, 1, 0};

  in_item_t  pending_items[$];
  out_item_t expected_cmds[$];
  int  mismatches;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  want_hold;
  bit  hold_done;
  int  hold_left;

  // exp(-(i*pi/DEPTH)^2) in Q16: a 13-term series for exp(-x/16) in Q30,
  // then four squarings bring it back to exp(-x).
  function automatic longint unsigned gauss_q16(input longint unsigned i);
    longint unsigned ang;
    longint unsigned sq;
    longint unsigned t;
    longint unsigned term;
    longint          acc;
    longint unsigned s;
    longint unsigned q;
    ang  = i * 64'd3373259426 / GAIN_TABLE_DEPTH;
    sq   = (ang * ang) >> 30;
    t    = sq >> 4;
    term = 64'd1 << 30;
    acc  = 64'd1 << 30;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * t) >> 30) / n;
      acc  = (n & 1) ? acc - longint'(term) : acc + longint'(term);
    end
    s = (acc < 0) ? 0 : acc;
    if (s > (64'd1 << 30)) begin
      s = 64'd1 << 30;
    end
    for (int n = 0; n < 4; n++) begin
      s = (s * s) >> 30;
    end
    q = (s + (64'd1 << 13)) >> 14;
    return (q > 65535) ? 65535 : q;
  endfunction

  // Works out the drive command for one accepted item; returns 1 when the
  // item produces a result.
  function automatic bit predict_drive(input in_item_t it, output out_item_t cmd);
    longint dx;
    longint dz;
    longint vx;
    longint vy;
    longint nx;
    longint unsigned range_mm;
    longint unsigned num;
    longint unsigned den;
    longint unsigned idx;
    longint unsigned adv;
    int z;
    logic signed [ANGLE_BITS-1:0] bearing;
    cmd = '0;
    if (it.command == CMD_SET_TARGET) begin
      goal_x = it.new_target_x;
      goal_y = it.new_target_y;
      armed  = 1'b1;
      return 1'b0;
    end
    if (!armed) begin
      return 1'b0;
    end
    dx = longint'(goal_x) - longint'(it.robot_x);
    dz = longint'(goal_y) - longint'(it.robot_z);
    vx = dz * 256;
    vy = dx * 256;
    z  = 0;
    if (vx < 0) begin
      vx = -vx;
      vy = -vy;
      z  = 32768;
    end
    if (dx != 0 || dz != 0) begin
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        if (vy > 0) begin
          nx = vx + (vy >>> k);
          vy = vy - (vx >>> k);
          z  = z + cordic_atan[k];
        end else begin
          nx = vx - (vy >>> k);
          vy = vy + (vx >>> k);
          z  = z - cordic_atan[k];
        end
        vx = nx;
      end
    end else begin
      z = 0;
    end
    range_mm = ((vx < 0 ? 0 : vx) * 39797 + (64'd1 << 23)) >> 24;
    if (range_mm < stop_radius) begin
      armed = 1'b0;
      cmd.arrived = 1'b1;
      return 1'b1;
    end
    bearing = 16'(z + int'(it.robot_heading));
    idx = longint'(bearing < 0 ? -int'(bearing) : int'(bearing)) * GAIN_TABLE_DEPTH >> 15;
    if (idx > GAIN_TABLE_DEPTH - 1) begin
      idx = GAIN_TABLE_DEPTH - 1;
    end
    if (ramp_distance == 0 || range_mm >= ramp_distance) begin
      num = top_speed * heading_gain[idx];
      den = 65536;
    end else begin
      num = top_speed * heading_gain[idx] * range_mm;
      den = 65536 * longint'(ramp_distance);
    end
    adv = (num + den / 2) / den;
    if (adv > top_speed) begin
      adv = top_speed;
    end
    cmd.advance_speed = adv[SPEED_BITS-1:0];
    cmd.rotation      = bearing;
    return 1'b1;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Sender: a new item is offered only once the previous one has transferred.
  always @(posedge clk_i) begin
    if (!in_ch.valid || in_ch.ready) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.data  <= pending_items.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that makes the block
  // back up and refuse input.
  always @(posedge clk_i) begin
    if (want_hold && !hold_done && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check the result transfer first, then predict from the input
  // transfer of the same edge; a result can never belong to that input.
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_cmds.size() == 0) begin
        $error("unexpected result: advance_speed %0d rotation %0d arrived %0d",
               got.advance_speed, got.rotation, got.arrived);
        mismatches++;
      end else begin
        want = expected_cmds.pop_front();
        if (got.advance_speed !== want.advance_speed) begin
          $error("advance_speed: expected %0d, got %0d", want.advance_speed,
                 got.advance_speed);
          mismatches++;
        end
        if (got.rotation !== want.rotation) begin
          $error("rotation: expected %0d, got %0d", want.rotation, got.rotation);
          mismatches++;
        end
        if (got.arrived !== want.arrived) begin
          $error("arrived: expected %0d, got %0d", want.arrived, got.arrived);
          mismatches++;
        end
      end
    end
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      if (predict_drive(in_ch.data, want)) begin
        expected_cmds.push_back(want);
      end
    end
  end

  task automatic add_target(input int x, input int y);
    in_item_t it;
    it = '0;
    it.command       = CMD_SET_TARGET;
    it.new_target_x  = 16'(x);
    it.new_target_y  = 16'(y);
    it.robot_x       = 16'($urandom);
    it.robot_z       = 16'($urandom);
    it.robot_heading = 16'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic add_tick(input int x, input int z, input int h);
    in_item_t it;
    it = '0;
    it.command       = CMD_POSE_TICK;
    it.robot_x       = 16'(x);
    it.robot_z       = 16'(z);
    it.robot_heading = 16'(h);
    it.new_target_x  = 16'($urandom);
    it.new_target_y  = 16'($urandom);
    pending_items.push_back(it);
  endtask

  // Writes one register at the next edge; the caller lowers the enable.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_BITS'(val);
    case (idx)
      CFG_MAX_SPEED:      top_speed     = SPEED_BITS'(val);
      CFG_ARRIVAL_RADIUS: stop_radius   = RADIUS_BITS'(val);
      CFG_SLOW_DISTANCE:  ramp_distance = SLOW_BITS'(val);
      default: ;
    endcase
  endtask

  task automatic set_regs(input int spd, input int rad, input int slow);
    write_reg(CFG_MAX_SPEED, spd);
    write_reg(CFG_ARRIVAL_RADIUS, rad);
    write_reg(CFG_SLOW_DISTANCE, slow);
    write_reg(CFG_SPARE_IDX, $urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || expected_cmds.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic int clip16(input int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  // Mostly well-formed approaches: a target, then ticks closing in on it,
  // often ending inside the arrival radius. The rest is unstructured noise.
  task automatic add_random(input int count);
    int gx;
    int gy;
    int ox;
    int oz;
    int n;
    int span;
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 85) begin
        span = ($urandom_range(4) == 0) ? 32767 : 4000;
        gx = $urandom_range(2 * span) - span;
        gy = $urandom_range(2 * span) - span;
        add_target(gx, gy);
        n = $urandom_range(8, 2);
        span = $urandom_range(6000, 200);
        for (int k = 0; k < n; k++) begin
          ox = $urandom_range(2 * span) - span;
          oz = $urandom_range(2 * span) - span;
          if (k == n - 1 && $urandom_range(9) < 4) begin
            ox = $urandom_range(120) - 60;
            oz = $urandom_range(120) - 60;
          end
          add_tick(clip16(gx - ox), clip16(gy - oz), int'(16'($urandom)));
          span = span / 2 + 1;
        end
        sent += n + 1;
      end else begin
        if ($urandom_range(1)) begin
          add_target(int'(16'($urandom)), int'(16'($urandom)));
        end else begin
          add_tick(int'(16'($urandom)), int'(16'($urandom)), int'(16'($urandom)));
        end
        sent++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < GAIN_TABLE_DEPTH; i++) begin
      heading_gain[i] = gauss_q16(i);
    end
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    want_hold      = 1'b0;
    hold_done      = 1'b0;
    hold_left      = 0;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    out_ch.ready   = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    top_speed      = 1000;
    stop_radius    = 100;
    ramp_distance  = 1000;
    goal_x         = '0;
    goal_y         = '0;
    armed          = 1'b0;
    rst_ni         = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset defaults.
    add_tick(-32768, -32768, -32768);        // disarmed: no result
    add_target(32767, 32767);
    add_tick(-32768, -32768, -32768);        // farthest corner, half-turn heading
    add_tick(32767, -32768, 32767);
    add_target(-32768, -32768);
    add_tick(32767, 32767, 0);
    add_target(0, 500);
    add_tick(0, 0, 0);                       // straight ahead, inside slow zone
    add_tick(0, 1000, 0);                    // goal straight behind
    add_tick(-400, 500, 16384);
    add_tick(400, 500, -16384);
    add_tick(0, 450, 0);                     // reaches the goal
    add_tick(0, 0, 0);                       // disarmed again
    add_target(100, 100);
    add_tick(100, 100, 1234);                // goal on the robot: arrival
    drain();

    // Radius zero never arrives, so a goal on the robot reports its heading as rotation.
    set_regs(4095, 0, 32767);
    add_target(5, 5);
    add_tick(5, 5, 16384);
    add_tick(5, 5, -32768);
    add_tick(-32768, 32767, 100);
    drain();
    set_regs(2047, 50, 0);                   // no slow-down zone
    add_target(-300, 700);
    add_tick(0, 0, 0);
    add_tick(-300, 690, -500);
    drain();

    // Random phases, each under its own idling pattern and register setting.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  set_regs(1000, 100, 1000); end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  set_regs(0, 4095, 1); end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; set_regs(4095, 0, 32767); end
        default: begin
          send_idle_pct = 11; recv_stall_pct = 11;
          set_regs($urandom_range(4095), $urandom_range(300), $urandom_range(32767, 1));
        end
      endcase
      add_random(375);
      if (p == 0) begin
        want_hold = 1'b1;
      end
      drain();
    end

    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("PASS go_to_point_drive_controller_unit");
    end else begin
      $display("FAIL go_to_point_drive_controller_unit");
    end
    $finish;
  end

  // Watchdog: a run that has not finished by this time fails.
  initial begin
    #20ms;
    $display("FAIL go_to_point_drive_controller_unit");
    $finish;
  end

endmodule

`default_nettype wire
